### rtl/sha_pkg.sv
package sha_pkg;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } sha_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       take_byte;
    logic       pad_write;
    logic [5:0] pad_addr;
    logic [7:0] pad_byte;
    logic       load;
    logic       round;
    logic [5:0] round_idx;
    logic       fold;
    logic       restart;
    logic [2:0] emit_idx;
  } sha_cmd_t;

  typedef logic [31:0] word_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam int unsigned LEN_POS = 56;

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic word_t ror32(word_t v, int unsigned s);
    ror32 = (v >> s) | (v << (32 - s));
  endfunction

endpackage

### rtl/sha_if.sv
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### rtl/sha_datapath.sv
module sha_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  sha_pkg::sha_cmd_t cmd,
  input  logic [7:0]        data_byte,
  output logic [5:0]        fill_cnt,
  output logic [63:0]       msg_bits,
  output logic [31:0]       digest_word
);
  import sha_pkg::*;

  logic [7:0]  blk_mem [64];
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  word_t       h_r [8];
  word_t       v_r [8];
  word_t       w_r [16];
  word_t       w_new, w_cur, t1, t2, e, a, w15, w2;

  assign fill_cnt    = fill_r;
  assign msg_bits    = bits_r;
  assign digest_word = h_r[cmd.emit_idx];

  // Block store writes
  always_ff @(posedge clk) begin
    if (cmd.take_byte) blk_mem[fill_r] <= data_byte;
    else if (cmd.pad_write) blk_mem[cmd.pad_addr] <= cmd.pad_byte;
  end

  // Fill count and bit count
  always_comb begin
    fill_nxt = fill_r;
    bits_nxt = bits_r;
    if (cmd.take_byte) begin
      fill_nxt = fill_r + 6'd1;
      bits_nxt = bits_r + 64'd8;
    end
    if (cmd.restart) begin
      fill_nxt = '0;
      bits_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      bits_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      bits_r <= bits_nxt;
    end
  end

  // Round logic
  always_comb begin
    w15 = w_r[1];
    w2  = w_r[14];
    w_new = w_r[0] + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3)) + w_r[9]
          + (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10));
    w_cur = w_r[0];
    a = v_r[0];
    e = v_r[4];
    t1 = v_r[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
       + ((e & v_r[5]) ^ (~e & v_r[6])) + ROUND_K[cmd.round_idx] + w_cur;
    t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
       + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // Schedule window: load packs four bytes per word, big-endian; w_r[0] is the
  // current word during rounds and the window shifts one each round
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r[cmd.round_idx[5:2]] <= {w_r[cmd.round_idx[5:2]][23:0], blk_mem[cmd.round_idx]};
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= w_new;
    end
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= e;
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= a;
      v_r[0] <= t1 + t2;
    end
  end

  // Chaining words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
    end else if (cmd.restart) begin
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end
endmodule

### rtl/sha_ctrl.sv
module sha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_byte_valid,
  input  logic              in_end,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_index,
  output logic              out_last,
  input  logic [5:0]        fill_cnt,
  input  logic [63:0]       msg_bits,
  output sha_pkg::sha_cmd_t cmd
);
  import sha_pkg::*;

  sha_state_t state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;     // load byte count / round count / emit index
  logic [6:0] pad_r, pad_nxt;     // pad write position
  logic       fin_r, fin_nxt;     // finishing message
  logic       two_r, two_nxt;     // padding needs a second block
  logic       pad_started_r, pad_started_nxt;
  logic       acc, full;

  assign acc  = in_valid && in_ready;
  assign full = in_byte_valid && (fill_cnt == 6'd63);

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pad_nxt   = pad_r;
    fin_nxt   = fin_r;
    two_nxt   = two_r;
    unique case (state_r)
      ST_FILL: begin
        if (acc) begin
          if (full) begin
            state_nxt = ST_LOAD;
            cnt_nxt   = '0;
            fin_nxt   = in_end;
            two_nxt   = 1'b0;
            pad_nxt   = '0;
          end else if (in_end) begin
            state_nxt = ST_PAD;
            fin_nxt   = 1'b1;
            pad_nxt   = {1'b0, fill_cnt} + {6'd0, in_byte_valid};
            two_nxt   = ({1'b0, fill_cnt} + {6'd0, in_byte_valid}) >= 7'd56;
          end
        end
      end
      ST_PAD: begin
        pad_nxt = pad_r + 7'd1;
        if (pad_r == 7'd63) begin
          state_nxt = ST_LOAD;
          cnt_nxt   = '0;
        end
      end
      ST_LOAD: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          state_nxt = ST_ROUND;
          cnt_nxt   = '0;
        end
      end
      ST_ROUND: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        cnt_nxt = '0;
        if (!fin_r) begin
          state_nxt = ST_FILL;
        end else if (two_r || !pad_started_r) begin
          // Pad a whole block from byte 0: zeros and length after a spilled
          // pad, or marker, zeros and length after a full block with end
          state_nxt = ST_PAD;
          two_nxt   = 1'b0;
          pad_nxt   = '0;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r == 7'd7) begin
            state_nxt = ST_FILL;
            fin_nxt   = 1'b0;
          end
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  // Track whether padding has been written for this message
  always_comb begin
    pad_started_nxt = pad_started_r;
    if (state_r == ST_PAD) pad_started_nxt = 1'b1;
    if (state_r == ST_EMIT) pad_started_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_FILL;
      cnt_r         <= '0;
      pad_r         <= '0;
      fin_r         <= 1'b0;
      two_r         <= 1'b0;
      pad_started_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      pad_r         <= pad_nxt;
      fin_r         <= fin_nxt;
      two_r         <= two_nxt;
      pad_started_r <= pad_started_nxt;
    end
  end

  // Outputs and commands
  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    out_index     = cnt_r[2:0];
    out_last      = (cnt_r[2:0] == 3'd7);
    cmd.emit_idx  = cnt_r[2:0];
    cmd.round_idx = cnt_r[5:0];
    unique case (state_r)
      ST_FILL: begin
        in_ready       = 1'b1;
        cmd.take_byte  = acc && in_byte_valid;
      end
      ST_PAD: begin
        cmd.pad_write = 1'b1;
        cmd.pad_addr  = pad_r[5:0];
        if (pad_r == {1'b0, fill_cnt} && !pad_started_r) cmd.pad_byte = PAD_MARK;
        else if (pad_r >= 7'(LEN_POS) && !two_r)
          cmd.pad_byte = msg_bits[8 * (7 - (pad_r[2:0])) +: 8];
        else cmd.pad_byte = '0;
      end
      ST_LOAD:  cmd.load  = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_FOLD:  cmd.fold  = 1'b1;
      ST_EMIT: begin
        out_valid   = 1'b1;
        cmd.restart = out_ready && (cnt_r == 7'd7);
      end
      default: ;
    endcase
  end
endmodule

### rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher.
// in_*  : one request per message byte; in_byte_valid marks a real byte and
//         in_end_of_message finishes the message (pad, final compress, digest).
// out_* : eight digest words per message, word 0 (most significant) first,
//         out_last_word high on word 7.
// A byte that does not fill a block is taken while in_ready stays high. A
// block that fills is loaded byte by byte into the schedule window, run through
// 64 rounds on the single round unit and folded into the chaining words, with
// in_ready low throughout. The end of a message adds a padding pass from the pad
// position up to byte 63 and a compression; when the length spills over, or the
// end rides on a byte that fills a block, a second whole-block pass and a
// compression follow. Then come the eight words, one per cycle; each holds
// until out_ready and a stalled receiver freezes the block in the emit state.
// After reset the chaining words hold the standard initial values and the
// byte and bit counts are zero; the block is ready at once.
module sha256_stream_hasher (
  input  logic clk,
  input  logic rst_n,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);
  import sha_pkg::*;

  sha_cmd_t    cmd;
  logic [5:0]  fill_cnt;
  logic [63:0] msg_bits;

  sha_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_byte_valid (in_ch.byte_valid),
    .in_end        (in_ch.end_of_message),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_index     (out_ch.word_index),
    .out_last      (out_ch.last_word),
    .fill_cnt      (fill_cnt),
    .msg_bits      (msg_bits),
    .cmd           (cmd)
  );

  sha_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_ch.data_byte),
    .fill_cnt    (fill_cnt),
    .msg_bits    (msg_bits),
    .digest_word (out_ch.digest_word)
  );

  // Never take input while a digest is shown
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("input taken during digest");

  // Last word flag only on index seven
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.last_word == (out_ch.word_index == 3'd7)))
    else $error("last flag mismatch");

  // Stalled word holds its index
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.word_index)))
    else $error("digest word dropped");
endmodule
